FILE: hdl/iupac_sequence_matcher_defines.svh
// Assertion macros shared by the matcher RTL.
`ifndef IUPAC_SEQUENCE_MATCHER_DEFINES_SVH
`define IUPAC_SEQUENCE_MATCHER_DEFINES_SVH

// Checked at every rising edge, masked while reset is asserted.
`define ISM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same, but the property is a next-cycle implication from the caller's pre and post.
`define ISM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/ism_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ism_pkg;

    localparam int OUT_WIDTH = 16;
    localparam int BASE_WIDTH = 8;
    localparam int SYM_COUNT = 18;

    typedef logic [SYM_COUNT-1:0] t_sym_mask;
    typedef logic [BASE_WIDTH-1:0] t_base;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};

    // One bit per symbol of the IUPAC alphabet plus gap and unknown marks
    localparam t_sym_mask SYM_A    = t_sym_mask'(1) << 0;
    localparam t_sym_mask SYM_C    = t_sym_mask'(1) << 1;
    localparam t_sym_mask SYM_G    = t_sym_mask'(1) << 2;
    localparam t_sym_mask SYM_T    = t_sym_mask'(1) << 3;
    localparam t_sym_mask SYM_R    = t_sym_mask'(1) << 4;
    localparam t_sym_mask SYM_Y    = t_sym_mask'(1) << 5;
    localparam t_sym_mask SYM_S    = t_sym_mask'(1) << 6;
    localparam t_sym_mask SYM_W    = t_sym_mask'(1) << 7;
    localparam t_sym_mask SYM_K    = t_sym_mask'(1) << 8;
    localparam t_sym_mask SYM_M    = t_sym_mask'(1) << 9;
    localparam t_sym_mask SYM_B    = t_sym_mask'(1) << 10;
    localparam t_sym_mask SYM_D    = t_sym_mask'(1) << 11;
    localparam t_sym_mask SYM_H    = t_sym_mask'(1) << 12;
    localparam t_sym_mask SYM_V    = t_sym_mask'(1) << 13;
    localparam t_sym_mask SYM_N    = t_sym_mask'(1) << 14;
    localparam t_sym_mask SYM_DOT  = t_sym_mask'(1) << 15;
    localparam t_sym_mask SYM_DASH = t_sym_mask'(1) << 16;
    localparam t_sym_mask SYM_QM   = t_sym_mask'(1) << 17;
    localparam t_sym_mask SYM_NONE = '0;

    // Only upper-case letters fold; everything else passes as is
    function automatic t_base fold_case(input t_base c);
        t_base r;
        r = c;
        if (c inside {["A":"Z"]}) begin
            r = c + t_base'(32);
        end
        return r;
    endfunction

    function automatic t_sym_mask sym_of(input t_base c);
        t_sym_mask m;
        case (fold_case(c))
            "a":     m = SYM_A;
            "c":     m = SYM_C;
            "g":     m = SYM_G;
            "t":     m = SYM_T;
            "r":     m = SYM_R;
            "y":     m = SYM_Y;
            "s":     m = SYM_S;
            "w":     m = SYM_W;
            "k":     m = SYM_K;
            "m":     m = SYM_M;
            "b":     m = SYM_B;
            "d":     m = SYM_D;
            "h":     m = SYM_H;
            "v":     m = SYM_V;
            "n":     m = SYM_N;
            ".":     m = SYM_DOT;
            "-":     m = SYM_DASH;
            "?":     m = SYM_QM;
            default: m = SYM_NONE;
        endcase
        return m;
    endfunction

    // Set of B symbols accepted by a given A code
    function automatic t_sym_mask accepted_set(input t_base a);
        t_sym_mask m;
        case (fold_case(a))
            "a": m = SYM_A | SYM_R | SYM_W | SYM_M | SYM_D | SYM_H | SYM_V | SYM_N;
            "c": m = SYM_C | SYM_Y | SYM_S | SYM_M | SYM_B | SYM_H | SYM_V | SYM_N;
            "g": m = SYM_G | SYM_R | SYM_S | SYM_K | SYM_B | SYM_D | SYM_V | SYM_N;
            "t": m = SYM_T | SYM_Y | SYM_W | SYM_K | SYM_B | SYM_D | SYM_H | SYM_N;
            "r": m = SYM_A | SYM_G | SYM_R | SYM_N;
            "y": m = SYM_C | SYM_T | SYM_Y | SYM_N;
            "s": m = SYM_G | SYM_C | SYM_S | SYM_N;
            "w": m = SYM_A | SYM_T | SYM_W | SYM_N;
            "k": m = SYM_G | SYM_T | SYM_K | SYM_N;
            "m": m = SYM_A | SYM_C | SYM_M | SYM_N;
            "b": m = SYM_C | SYM_G | SYM_T | SYM_B | SYM_N;
            "d": m = SYM_A | SYM_G | SYM_T | SYM_D | SYM_N;
            "h": m = SYM_A | SYM_C | SYM_T | SYM_H | SYM_N;
            "v": m = SYM_A | SYM_C | SYM_G | SYM_V | SYM_N;
            "n": m = SYM_A | SYM_C | SYM_G | SYM_T | SYM_R | SYM_Y | SYM_S | SYM_W
                   | SYM_K | SYM_M | SYM_B | SYM_D | SYM_H | SYM_V | SYM_N;
            ".", "-": m = SYM_DOT | SYM_DASH;
            "?":     m = SYM_QM;
            default: m = SYM_NONE;
        endcase
        return m;
    endfunction

    function automatic logic codes_match(input t_base a, input t_base b);
        return |(accepted_set(a) & sym_of(b));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/iupac_sequence_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_base_a, i_base_b, i_a_ends, i_b_ends
//  out     | o_out_valid| i_out_ready | o_equal, o_matching_positions
//
//  One base pair per cycle while the input does not stall. Each transfer lands in
//  an input register and is looked up there; a non-end item is folded into the
//  match state in the next cycle, while an end item waits until the result
//  register is free, then writes it and raises o_out_valid for the receiver. Reset (i_rst_n
//  low, synchronous) empties both registers and sets all-matched with a zero
//  count. Input stalls only while an end item sits in the input register and
//  the result register still holds an untaken result.

`include "iupac_sequence_matcher_defines.svh"

module iupac_sequence_matcher #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_base_a,
    input  wire logic [7:0]                   i_base_b,
    input  wire logic                         i_a_ends,
    input  wire logic                         i_b_ends,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_equal,
    output logic [ism_pkg::OUT_WIDTH-1:0]     o_matching_positions
);

    localparam int CW = COUNT_WIDTH;
    localparam int OW = ism_pkg::OUT_WIDTH;
    // common width for the saturating compare against the output range
    localparam int EW = (CW > OW) ? CW : OW;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // input register
    logic                   r_s1_valid;
    ism_pkg::t_base         r_s1_base_a;
    ism_pkg::t_base         r_s1_base_b;
    logic                   r_s1_a_ends;
    logic                   r_s1_b_ends;

    // running comparison state
    logic                   r_all_matched, n_all_matched;
    logic [CW-1:0]          r_match_count, n_match_count;

    // result register
    logic                   r_out_valid;
    logic                   r_equal;
    logic [OW-1:0]          r_match_out;

    logic                   s1_match;
    logic                   s1_end;
    logic                   s1_fire;
    logic                   out_free;
    logic [EW-1:0]          cnt_ext;
    logic [OW-1:0]          cnt_sat;

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_end   = r_s1_a_ends || r_s1_b_ends;
    // a non-end item only updates state, so it never waits on the output side
    assign s1_fire  = r_s1_valid && (!s1_end || out_free);

    assign o_in_ready = !r_s1_valid || s1_fire;

    assign s1_match = ism_pkg::codes_match(r_s1_base_a, r_s1_base_b);

    always_comb begin
        n_all_matched = r_all_matched & s1_match;
        n_match_count = r_match_count;
        if (s1_match && (r_match_count != CNT_MAX)) begin
            n_match_count = r_match_count + CW'(1);
        end
    end

    // count as reported: clamp to the output range
    assign cnt_ext = EW'(n_match_count);
    assign cnt_sat = (cnt_ext > EW'(ism_pkg::OUT_MAX)) ? ism_pkg::OUT_MAX
                                                       : cnt_ext[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_all_matched <= 1'b1;
            r_match_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end

            // a new result takes the slot even when the old one leaves now
            if (s1_fire && s1_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (s1_end) begin
                    // emit and start the next pair from the reset state
                    r_all_matched <= 1'b1;
                    r_match_count <= '0;
                end else begin
                    r_all_matched <= n_all_matched;
                    r_match_count <= n_match_count;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_base_a <= i_base_a;
            r_s1_base_b <= i_base_b;
            r_s1_a_ends <= i_a_ends;
            r_s1_b_ends <= i_b_ends;
        end
        if (s1_fire && s1_end) begin
            r_equal     <= r_s1_a_ends && r_s1_b_ends && n_all_matched;
            r_match_out <= cnt_sat;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_equal              = r_equal;
    assign o_matching_positions = r_match_out;

    `ISM_ASSERT_NEXT(a_state_clears, s1_fire && s1_end,
        r_all_matched && (r_match_count == '0), "state not cleared after end item")
    `ISM_ASSERT_NEXT(a_count_monotonic, s1_fire && !s1_end,
        r_match_count >= $past(r_match_count), "match count went down mid-sequence")
    `ISM_ASSERT(a_equal_has_count, (o_out_valid && o_equal) |-> (o_matching_positions != '0),
        "equal result reported with zero matches")
    `ISM_ASSERT(a_stall_cause,
        !o_in_ready |-> (r_s1_valid && s1_end && r_out_valid && !i_out_ready),
        "input stalled without a blocked end item")

endmodule

`default_nettype wire

FILE: bench/tb_iupac_sequence_matcher.sv
`timescale 1ns / 1ps

module tb_iupac_sequence_matcher;

    // Counter width of the matcher under test; output clamps at 16 bits regardless.
    localparam int CNT_W = 16;
    localparam longint unsigned TALLY_MAX = (64'd1 << CNT_W) - 64'd1;

    localparam int HALF_PERIOD_NS = 4;
    // Watchdog that ends a run which hangs.
    localparam longint TIMEOUT_NS = 64'd3_200_000;
    localparam int RANDOM_PAIRS = 860;
    // Length of the single long agreeing pair
    localparam int LONG_PAIR_LEN = 200;
    // Slack to wait once every verdict owed has been taken.
    localparam int SETTLE_CYCLES = 6;

    // Every symbol an A position can carry and still accept something.
    localparam string IUPAC_CODES = "acgtryswkmbdhvn.-?";

    typedef struct packed {
        logic        equal;
        logic [15:0] positions;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,     // always taking results
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready one cycle in four
        RX_TRICKLE   // ready one cycle in eight
    } rx_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    ism_pkg::t_base i_base_a = '0;
    ism_pkg::t_base i_base_b = '0;
    logic i_a_ends = 1'b0;
    logic i_b_ends = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_equal;
    logic [ism_pkg::OUT_WIDTH-1:0] o_matching_positions;

    iupac_sequence_matcher #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_base_a(i_base_a),
        .i_base_b(i_base_b),
        .i_a_ends(i_a_ends),
        .i_b_ends(i_b_ends),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_equal(o_equal),
        .o_matching_positions(o_matching_positions)
    );

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the comparison state and the verdicts still owed
    // ------------------------------------------------------------------
    logic             pair_all_agree = 1'b1;
    longint unsigned  agree_tally = 0;
    verdict_t         verdicts_due[$];
    int               mismatches = 0;
    int               pairs_sent = 0;

    // Sender pacing
    int  burst_left = 0;
    bit  steady = 1'b0;

    // Receiver long hold-off: request from the test, counted down by the receiver
    int  hold_req = 0;
    int  hold_left = 0;

    function automatic ism_pkg::t_base to_lower(input ism_pkg::t_base c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Lower-case B symbols that a given A symbol accepts; empty for an unknown A.
    function automatic string accepts_for(input ism_pkg::t_base a);
        case (to_lower(a))
            "a":      return "arwmdhvn";
            "c":      return "cysmbhvn";
            "g":      return "grskbdvn";
            "t":      return "tywkbdhn";
            "r":      return "agrn";
            "y":      return "ctyn";
            "s":      return "gcsn";
            "w":      return "atwn";
            "k":      return "gtkn";
            "m":      return "acmn";
            "b":      return "cgtbn";
            "d":      return "agtdn";
            "h":      return "acthn";
            "v":      return "acgvn";
            "n":      return "acgtryswkmbdhvn";
            ".", "-": return ".-";
            "?":      return "?";
            default:  return "";
        endcase
    endfunction

    function automatic bit bases_agree(input ism_pkg::t_base a, input ism_pkg::t_base b);
        string s;
        ism_pkg::t_base lb;
        s = accepts_for(a);
        lb = to_lower(b);
        for (int k = 0; k < s.len(); k++) begin
            if (s[k] == lb) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Fold one accepted pair into the shadow state; queue a verdict at a sequence end.
    task automatic score_pair(input ism_pkg::t_base a, input ism_pkg::t_base b,
                              input logic ae, input logic be);
        verdict_t v;
        if (bases_agree(a, b)) begin
            if (agree_tally < TALLY_MAX) begin
                agree_tally++;
            end
        end else begin
            pair_all_agree = 1'b0;
        end
        if (ae || be) begin
            v.equal = ae && be && pair_all_agree;
            v.positions = (agree_tally > 64'(ism_pkg::OUT_MAX)) ?
                          ism_pkg::OUT_MAX : agree_tally[15:0];
            verdicts_due.push_back(v);
            pair_all_agree = 1'b1;
            agree_tally = 0;
        end
    endtask

    task automatic report(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    // Watch both channels: predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin : watch_channels
        verdict_t due;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                score_pair(i_base_a, i_base_b, i_a_ends, i_b_ends);
            end
            if (o_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    report($sformatf("unexpected result equal=%0b positions=%0d",
                                     o_equal, o_matching_positions));
                end else begin
                    due = verdicts_due.pop_front();
                    if (o_equal !== due.equal) begin
                        report($sformatf("equal got %0b want %0b", o_equal, due.equal));
                    end
                    if (o_matching_positions !== due.positions) begin
                        report($sformatf("positions got %0d want %0d",
                                         o_matching_positions, due.positions));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, switching among four randomly chosen modes
    // ------------------------------------------------------------------
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_phase_left = 0;

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (rx_phase_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(20, 80);
        end else begin
            rx_phase_left--;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_OPEN:    i_out_ready <= 1'b1;
                RX_COIN:    i_out_ready <= $urandom_range(0, 1);
                RX_SPARSE:  i_out_ready <= ($urandom_range(0, 3) == 0);
                default:    i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one pair and hold it until the transfer. Called at a rising edge;
    // returns at the edge of the transfer with valid still high.
    task automatic send_pair(input ism_pkg::t_base a, input ism_pkg::t_base b,
                             input logic ae, input logic be);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_base_a <= a;
        i_base_b <= b;
        i_a_ends <= ae;
        i_b_ends <= be;
        do @(posedge i_clk); while (!o_in_ready);
        pairs_sent++;
    endtask

    // Stop offering and wait for every verdict owed, plus pipeline slack.
    // The first edge lets the watcher score the last transfer.
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic ism_pkg::t_base mixed_case(input ism_pkg::t_base c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic ism_pkg::t_base pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic ism_pkg::t_base any_code();
        return mixed_case(IUPAC_CODES[$urandom_range(0, IUPAC_CODES.len() - 1)]);
    endfunction

    // A byte that the given A symbol rejects
    function automatic ism_pkg::t_base rejected_by(input ism_pkg::t_base a);
        ism_pkg::t_base b;
        b = 8'($urandom);
        while (bases_agree(a, b)) begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every A symbol once, each with an accepted B in random case: one equal pair.
    task automatic test_iupac_codes();
        ism_pkg::t_base a;
        logic last;
        for (int k = 0; k < IUPAC_CODES.len(); k++) begin
            a = mixed_case(IUPAC_CODES[k]);
            last = (k == IUPAC_CODES.len() - 1);
            send_pair(a, mixed_case(pick_from(accepts_for(a))), last, last);
        end
        drain_verdicts();
    endtask

    // Unknown A, bytes outside the letter range, folding edges, unequal lengths.
    task automatic test_odd_bytes();
        send_pair("x", "x", 1'b1, 1'b1);       // unknown A never agrees
        send_pair(8'h00, 8'hFF, 1'b1, 1'b0);   // A ends alone
        send_pair(8'hFF, 8'h00, 1'b0, 1'b1);   // B ends alone
        send_pair(8'hC1, "a", 1'b1, 1'b1);     // high byte is not folded
        send_pair("@", "@", 1'b1, 1'b1);       // just below 'A'
        send_pair("N", "N", 1'b0, 1'b0);
        send_pair("T", 8'hD4, 1'b0, 1'b0);     // 'T' with top bit set in B
        send_pair("Z", "z", 1'b0, 1'b1);       // 'z' is no code; B ends first
        drain_verdicts();
    endtask

    // One long agreeing pair sent back to back: the tally climbs well past short pairs.
    task automatic test_long_pair();
        ism_pkg::t_base a;
        int n;
        n = LONG_PAIR_LEN;
        steady = 1'b1;
        for (int k = 0; k < n; k++) begin
            a = pick_from("acgtn");
            send_pair(a, a, k == n - 1, k == n - 1);
        end
        steady = 1'b0;
        drain_verdicts();
    endtask

    // Receiver holds off while short pairs keep coming: the block must fill and stall.
    task automatic test_backpressure();
        ism_pkg::t_base a;
        steady = 1'b1;
        hold_req = 300;
        for (int k = 0; k < 60; k++) begin
            a = any_code();
            send_pair(a, ($urandom_range(0, 3) == 0) ? rejected_by(a) :
                      mixed_case(pick_from(accepts_for(a))),
                      $urandom_range(0, 1), 1'b1);
        end
        steady = 1'b0;
        drain_verdicts();
    endtask

    // Mostly well-formed pairs with random content, some with a bad position,
    // some pure noise, and some whose lengths disagree.
    task automatic test_random_pairs();
        int start;
        int len;
        int kind;
        int bad_at;
        int end_kind;
        logic last;
        ism_pkg::t_base a;
        ism_pkg::t_base b;
        start = pairs_sent;
        while (pairs_sent - start < RANDOM_PAIRS) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            kind = $urandom_range(0, 19);
            bad_at = $urandom_range(0, len - 1);
            end_kind = $urandom_range(0, 7);
            steady = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++) begin
                last = (k == len - 1);
                if (kind < 3) begin
                    a = 8'($urandom);
                    b = 8'($urandom);
                end else begin
                    a = any_code();
                    if (kind < 7 && k == bad_at) begin
                        b = rejected_by(a);
                    end else begin
                        b = mixed_case(pick_from(accepts_for(a)));
                    end
                end
                send_pair(a, b, last && end_kind != 1, last && end_kind != 0);
            end
        end
        steady = 1'b0;
        drain_verdicts();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_iupac_codes();
        test_odd_bytes();
        test_backpressure();
        test_long_pair();
        test_random_pairs();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: iupac_sequence_matcher.f
+incdir+hdl
hdl/ism_pkg.sv
hdl/iupac_sequence_matcher.sv
bench/tb_iupac_sequence_matcher.sv
